// ===== rtl/rfes_pkg.sv =====
package rfes_pkg;

  typedef enum logic [1:0] {
    SEC_HDR = 2'd0,
    SEC_REC = 2'd1,
    SEC_UP  = 2'd2,
    SEC_DN  = 2'd3
  } section_t;

  localparam int MAX_FIELDS  = 10;
  localparam int FIELD_BYTES = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  // report header output positions that carry the record count
  localparam logic [15:0] HDR_CNT_HI_POS = 16'd13;
  localparam logic [15:0] HDR_CNT_LO_POS = 16'd14;

  // register index decoded from paddr[2]
  localparam logic REG_REPORT_LENGTH = 1'b0;

  typedef struct packed {
    logic [FIELD_BYTES-1:0][7:0] bytes;  // arrival order
    logic [2:0]                  wm1;    // field width minus one
    section_t                    sec;
  } rfes_job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } rfes_qstat_t;

  function automatic logic [3:0] field_count(section_t s);
    logic [3:0] n;
    case (s)
      SEC_HDR: n = 4'd6;
      SEC_REC: n = 4'd1;
      SEC_UP:  n = 4'd10;
      SEC_DN:  n = 4'd4;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] field_width(section_t s, logic [3:0] f);
    logic [3:0] w;
    w = 4'd1;
    case (s)
      SEC_HDR: begin
        case (f)
          4'd0, 4'd1, 4'd4: w = 4'd2;
          4'd2:             w = 4'd8;
          default:          w = 4'd1;
        endcase
      end
      SEC_REC: begin
        case (f)
          4'd0:    w = 4'd4;
          default: w = 4'd1;
        endcase
      end
      SEC_UP: begin
        case (f)
          4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8: w = 4'd2;
          default:                           w = 4'd1;
        endcase
      end
      SEC_DN: begin
        case (f)
          4'd0:    w = 4'd2;
          4'd2:    w = 4'd4;
          default: w = 4'd1;
        endcase
      end
      default: w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/report_field_endian_swapper.sv =====
// Order: a field enters the queue when its last input byte is accepted; its bytes are then
//   registered at the output one per cycle while the output is not stalled, last byte of
//   the field first.
// Throughput: one input byte per cycle; input stalls only while the 4-entry field queue
//   between front and emitter is full; emitter drains one byte per cycle unless stalled.
// Reset (rst_n low, synchronous): layout state, queue and out_valid clear, report_length 0.
module report_field_endian_swapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_section,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfes_pkg::*;

  logic        [15:0] len_r;
  logic               cfg_wr;
  logic               push;
  logic               pop;
  rfes_job_t          push_job;
  rfes_job_t          head_job;
  rfes_qstat_t        q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_REPORT_LENGTH) begin
      len_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_REPORT_LENGTH) ? {16'd0, len_r} : 32'd0;

  rfes_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .report_length  (len_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .q_stat         (q_stat),
    .push           (push),
    .push_job       (push_job)
  );

  rfes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  rfes_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .q_valid     (q_stat.valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_section (out_section),
    .out_last    (out_last)
  );

endmodule

// ===== rtl/rfes_front.sv =====
module rfes_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         report_length,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_frame_start,
  input  rfes_pkg::rfes_qstat_t q_stat,
  output logic                push,
  output rfes_pkg::rfes_job_t push_job
);
  import rfes_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  section_t    sec_r, sec_nxt;
  logic [3:0]  fld_r, fld_nxt;
  logic [2:0]  bif_r, bif_nxt;
  logic [4:0]  rec_r, rec_nxt;
  logic [2:0]  up_r, up_nxt;
  logic [2:0]  dn_r, dn_nxt;
  logic [7:0]  cc0_r, cc0_nxt;
  logic [7:0]  cc1_r, cc1_nxt;
  logic [7:0]  buf_r [FIELD_BYTES];

  // view of the state after an optional restart
  logic [15:0] b_pos;
  section_t    b_sec;
  logic [3:0]  b_fld;
  logic [2:0]  b_bif;
  logic [4:0]  b_rec;
  logic [2:0]  b_up;
  logic [2:0]  b_dn;
  logic [7:0]  b_cc0;
  logic [7:0]  b_cc1;

  logic        accept;
  logic [3:0]  fit_v;
  logic        go;
  logic        kill;
  logic [3:0]  fld_use;
  logic [3:0]  nfld;
  logic        found;
  logic [2:0]  wm1;
  logic        complete;
  logic        buf_we;
  rfes_job_t   job;

  function automatic logic pick_fit(logic [3:0] w, logic [3:0] fv);
    logic r;
    case (w)
      4'd1:    r = fv[0];
      4'd2:    r = fv[1];
      4'd4:    r = fv[2];
      4'd8:    r = fv[3];
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_frame_start) begin
      b_pos = '0;
      b_sec = SEC_HDR;
      b_fld = '0;
      b_bif = '0;
      b_rec = '0;
      b_up  = '0;
      b_dn  = '0;
      b_cc0 = '0;
      b_cc1 = '0;
    end else begin
      b_pos = pos_r;
      b_sec = sec_r;
      b_fld = fld_r;
      b_bif = bif_r;
      b_rec = rec_r;
      b_up  = up_r;
      b_dn  = dn_r;
      b_cc0 = cc0_r;
      b_cc1 = cc1_r;
    end
  end

  // fit tests for the four field widths at the current byte position
  always_comb begin
    fit_v[0] = ({1'b0, b_pos} + 17'd1) <= {1'b0, report_length};
    fit_v[1] = ({1'b0, b_pos} + 17'd2) <= {1'b0, report_length};
    fit_v[2] = ({1'b0, b_pos} + 17'd4) <= {1'b0, report_length};
    fit_v[3] = ({1'b0, b_pos} + 17'd8) <= {1'b0, report_length};
  end

  // next field of this section that fits
  always_comb begin
    found = 1'b0;
    nfld  = b_fld;
    for (int f = 0; f < MAX_FIELDS; f++) begin
      if (!found && 4'(f) > b_fld && 4'(f) < field_count(b_sec) &&
          pick_fit(field_width(b_sec, 4'(f)), fit_v)) begin
        found = 1'b1;
        nfld  = 4'(f);
      end
    end
  end

  // field selection: continue, start, skip forward, or drop to end of layout
  always_comb begin
    go      = 1'b0;
    kill    = 1'b0;
    fld_use = b_fld;
    if (b_bif != 3'd0) begin
      go = 1'b1;
    end else if (b_sec == SEC_REC && b_rec == 5'd0) begin
      go = 1'b0;
    end else if (pick_fit(field_width(b_sec, b_fld), fit_v)) begin
      go = 1'b1;
    end else if (!fit_v[0] || b_sec == SEC_REC || !found) begin
      // nothing further fits, or a record field does not fit: every remaining field is skipped
      kill = 1'b1;
    end else begin
      go      = 1'b1;
      fld_use = nfld;
    end
    wm1      = 3'(field_width(b_sec, fld_use) - 4'd1);
    complete = go && (b_bif == wm1);
  end

  always_comb begin
    for (int j = 0; j < FIELD_BYTES; j++) begin
      job.bytes[j] = (3'(j) == wm1) ? in_data_byte : buf_r[j];
    end
    job.wm1 = wm1;
    job.sec = b_sec;
  end

  // next state
  always_comb begin
    pos_nxt = b_pos;
    sec_nxt = b_sec;
    fld_nxt = fld_use;
    bif_nxt = b_bif;
    rec_nxt = b_rec;
    up_nxt  = b_up;
    dn_nxt  = b_dn;
    cc0_nxt = b_cc0;
    cc1_nxt = b_cc1;
    if (kill) begin
      sec_nxt = SEC_REC;
      fld_nxt = '0;
      rec_nxt = '0;
      up_nxt  = '0;
      dn_nxt  = '0;
    end else if (go && !complete) begin
      bif_nxt = b_bif + 3'd1;
      pos_nxt = b_pos + 16'd1;
    end else if (complete) begin
      pos_nxt = b_pos + 16'd1;
      bif_nxt = '0;
      if (b_sec == SEC_HDR) begin
        for (int j = 0; j < FIELD_BYTES; j++) begin
          if (3'(j) <= wm1 && (b_pos - 16'(j)) == HDR_CNT_HI_POS) cc0_nxt = job.bytes[j];
          if (3'(j) <= wm1 && (b_pos - 16'(j)) == HDR_CNT_LO_POS) cc1_nxt = job.bytes[j];
        end
      end else if (b_sec == SEC_REC) begin
        cc0_nxt = job.bytes[2];
        cc1_nxt = job.bytes[1];
      end
      if ((fld_use + 4'd1) < field_count(b_sec)) begin
        fld_nxt = fld_use + 4'd1;
      end else begin
        fld_nxt = '0;
        case (b_sec)
          SEC_HDR: rec_nxt = {cc0_nxt[2:0], cc1_nxt[7:6]};
          SEC_REC: begin
            up_nxt  = {cc0_nxt[0], cc1_nxt[7:6]};
            dn_nxt  = cc0_nxt[3:1];
            rec_nxt = b_rec - 5'd1;
          end
          SEC_UP:  up_nxt = b_up - 3'd1;
          SEC_DN:  dn_nxt = b_dn - 3'd1;
          default: rec_nxt = b_rec;
        endcase
        if (b_sec == SEC_HDR) begin
          sec_nxt = SEC_REC;
        end else if (up_nxt != 3'd0) begin
          sec_nxt = SEC_UP;
        end else if (dn_nxt != 3'd0) begin
          sec_nxt = SEC_DN;
        end else begin
          sec_nxt = SEC_REC;
        end
      end
    end
  end

  // outputs
  always_comb begin
    push     = accept && complete;
    buf_we   = accept && go && !complete;
    push_job = job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sec_r <= SEC_HDR;
      fld_r <= '0;
      bif_r <= '0;
      rec_r <= '0;
      up_r  <= '0;
      dn_r  <= '0;
      cc0_r <= '0;
      cc1_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      sec_r <= sec_nxt;
      fld_r <= fld_nxt;
      bif_r <= bif_nxt;
      rec_r <= rec_nxt;
      up_r  <= up_nxt;
      dn_r  <= dn_nxt;
      cc0_r <= cc0_nxt;
      cc1_r <= cc1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[b_bif] <= in_data_byte;
    end
  end

endmodule

// ===== rtl/rfes_queue.sv =====
module rfes_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rfes_pkg::rfes_job_t   push_job,
  input  logic                  pop,
  output rfes_pkg::rfes_job_t   head_job,
  output rfes_pkg::rfes_qstat_t q_stat
);
  import rfes_pkg::*;

  rfes_job_t          mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_pop;

  assign q_stat.full  = (cnt_r == (Q_PTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign head_job     = mem_r[rd_ptr_r];
  assign do_pop       = pop && q_stat.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + (Q_PTR_W)'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + (Q_PTR_W)'(1);
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + (Q_PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (Q_PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("field queue written while full");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PTR_W+1)'(QUEUE_DEPTH))
    else $error("field queue count out of range");
`endif

endmodule

// ===== rtl/rfes_back.sv =====
module rfes_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rfes_pkg::rfes_job_t head_job,
  input  logic                q_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_section,
  output logic                out_last
);
  import rfes_pkg::*;

  logic [2:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [1:0] out_section_r;
  logic       out_last_r;
  logic       emit;
  logic       is_last;
  logic [2:0] idx;

  assign emit    = q_valid && (!out_valid_r || out_ready);
  assign is_last = (k_r == head_job.wm1);
  assign idx     = head_job.wm1 - k_r;
  assign pop     = emit && is_last;

  always_comb begin
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      k_nxt         = is_last ? 3'd0 : k_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // emit the field last byte first
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r    <= head_job.bytes[idx];
      out_section_r <= head_job.sec;
      out_last_r    <= is_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_section = out_section_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> k_r <= head_job.wm1)
    else $error("byte index past field width");
  a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> k_r == 3'd0)
    else $error("byte index not cleared with queue empty");
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> k_r == 3'd0)
    else $error("byte index not cleared after field done");
`endif

endmodule
